[hw/rtl/pnf_pkg.sv]
// pnf_pkg: shared constants, codes and fixed-point helpers for the
// Perlin fBm noise block. No dependencies.
package pnf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int COORD_W     = 8 + FRAC_BITS;
	localparam int TABLE_AW    = 8;
	localparam int TABLE_SIZE  = 1 << TABLE_AW;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = 4;
	localparam int AMP_W       = 16;
	localparam int CFG_W       = 16;
	localparam int T_W         = FRAC_BITS + 2;
	localparam int FW          = FRAC_BITS + 6;
	localparam int DW          = FRAC_BITS + 3;
	localparam int LW          = FRAC_BITS + 6;
	localparam int ACC_W       = FRAC_BITS + 8;
	localparam int OUT_W       = FRAC_BITS + 3;
	localparam int FADE_CELLS  = 4;

	localparam logic [OCT_W-1:0] OCT_RESET = OCT_W'(6);
	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(58982);

	localparam logic CFG_OCTAVES = 1'b0;
	localparam logic CFG_AMP     = 1'b1;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [1:0] GRAD_PP = 2'd0;
	localparam logic [1:0] GRAD_NP = 2'd1;
	localparam logic [1:0] GRAD_NN = 2'd2;
	localparam logic [1:0] GRAD_PN = 2'd3;

	function automatic logic signed [DW-1:0] grad_dot(input logic [1:0] h,
			input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
		case (h)
			GRAD_PP: grad_dot = dx + dy;
			GRAD_NP: grad_dot = dy - dx;
			GRAD_NN: grad_dot = -dx - dy;
			GRAD_PN: grad_dot = dx - dy;
			default: grad_dot = dx + dy;
		endcase
	endfunction

	// a + floor(t*(b-a) / 2^F)
	function automatic logic signed [LW-1:0] lerp_q(input logic signed [T_W-1:0] t,
			input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
		logic signed [LW:0]        diff;
		logic signed [LW+T_W:0]    prod;
		diff = {b[LW-1], b} - {a[LW-1], a};
		prod = t * diff;
		lerp_q = a + prod[LW+FRAC_BITS-1:FRAC_BITS];
	endfunction

	// Horner constant of fade cell i: 6t^5-15t^4+10t^3 = ((((6t-15)t+10)t)t)t
	function automatic logic [FW-1:0] fade_k(input int i);
		fade_k = (i == 0) ? FW'(10 * ONE) : '0;
	endfunction

endpackage

[hw/rtl/pnf_fade_cell.sv]
// pnf_fade_cell: one Horner step y' = floor(y*t/2^F) + k of the fade chain.
// Depends on pnf_pkg.
module pnf_fade_cell (
	input  logic                             clk,
	input  logic signed [pnf_pkg::FW-1:0]    y_in,
	input  logic signed [pnf_pkg::T_W-1:0]   t_in,
	input  logic        [pnf_pkg::FW-1:0]    k_in,
	output logic signed [pnf_pkg::FW-1:0]    y_out,
	output logic signed [pnf_pkg::T_W-1:0]   t_out
);
	import pnf_pkg::*;

	logic signed [FW+T_W-1:0] prod;
	logic signed [FW-1:0]     y_q;
	logic signed [T_W-1:0]    t_q;

	assign prod = y_in * t_in;

	always_ff @(posedge clk) begin
		y_q <= prod[FW+FRAC_BITS-1:FRAC_BITS] + $signed(k_in);
		t_q <= t_in;
	end

	assign y_out = y_q;
	assign t_out = t_q;
endmodule

[hw/rtl/pnf_perm_ram.sv]
// pnf_perm_ram: 256-byte permutation table, one write and one registered read
// port; unwritten entries read as their own index. Depends on pnf_pkg.
module pnf_perm_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [pnf_pkg::TABLE_AW-1:0]  waddr,
	input  logic [7:0]                    wdata,
	input  logic [pnf_pkg::TABLE_AW-1:0]  raddr,
	output logic [7:0]                    rdata
);
	import pnf_pkg::*;

	logic [7:0]            mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] written_q;
	logic [7:0]            rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= written_q[raddr] ? mem[raddr] : 8'(raddr);
	end

	assign rdata = rdata_q;
endmodule

[hw/rtl/perlin_noise_fbm_2d.sv]
// perlin_noise_fbm_2d: top level, sequencer, lookups, lerps and accumulator.
// Depends on pnf_pkg, pnf_fade_cell and pnf_perm_ram.
//
// Input channel (in_valid/in_stall) takes one beat per item. A load beat
// (mode 0) writes perm_value at perm_index and yields nothing.
// A sample beat (mode 1) takes x_coord/y_coord in Q8.16 and yields one
// noise_height beat (signed Q2.16, saturated) on the output channel.
// A sample runs min(octave_count, 8) octaves, six at the reset count; with
// zero octaves it goes straight to the result. The octave time is set by
// the six dependent permutation reads through the single table read port
// followed by the lerp and amplitude multiplies. The fade polynomial
// runs in parallel in two rows of four Horner cells.
// in_stall is high while a sample is in work; one sample at a time.
// The result sits in an output register; a stalled output holds its beat
// while the block goes back to taking loads and the next sample, which then
// waits for the register before it finishes.
// Reset: table reads as identity, octave_count 6, start_amplitude 0.9,
// no result pending. Configuration is written through cfg_we/cfg_index.
module perlin_noise_fbm_2d (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pnf_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [7:0]                          perm_index,
	input  logic [7:0]                          perm_value,
	input  logic [pnf_pkg::COORD_W-1:0]         x_coord,
	input  logic [pnf_pkg::COORD_W-1:0]         y_coord,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pnf_pkg::OUT_W-1:0]    noise_height
);
	import pnf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_OCT  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	localparam logic [3:0] STEP_A0  = 4'd0;
	localparam logic [3:0] STEP_A1  = 4'd1;
	localparam logic [3:0] STEP_A2  = 4'd2;
	localparam logic [3:0] STEP_A3  = 4'd3;
	localparam logic [3:0] STEP_A4  = 4'd4;
	localparam logic [3:0] STEP_A5  = 4'd5;
	localparam logic [3:0] STEP_H11 = 4'd6;
	localparam logic [3:0] STEP_LY  = 4'd7;
	localparam logic [3:0] STEP_LX  = 4'd8;
	localparam logic [3:0] STEP_AMP = 4'd9;
	localparam logic [3:0] STEP_ACC = 4'd10;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (FRAC_BITS + 2)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(1 << (FRAC_BITS + 2));

	state_t                    state_q;
	logic [OCT_W-1:0]          oct_cnt_q;
	logic [AMP_W-1:0]          amp_cfg_q;
	logic [OCT_W-1:0]          oct_eff;
	logic [OCT_W-1:0]          oct_left_q;
	logic [3:0]                step_q;
	logic [COORD_W-1:0]        x_q, y_q;
	logic [AMP_W-1:0]          amp_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [7:0]                px0_q, px1_q;
	logic [1:0]                h00_q, h01_q, h10_q, h11_q;
	logic signed [LW-1:0]      ly0_q, ly1_q, nz_q;
	logic signed [ACC_W-1:0]   term_q;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   out_q;

	logic                      in_acc, ram_we;
	logic [7:0]                xi, yi, raddr, rdata;
	logic [FRAC_BITS-1:0]      fx, fy;
	logic signed [DW-1:0]      dx0, dx1, dy0, dy1;
	logic signed [T_W-1:0]     u, v;
	logic signed [AMP_W+LW:0]  amp_prod;
	logic signed [ACC_W-1:0]   acc_sat;

	logic signed [FW-1:0]      ux_y [FADE_CELLS+1];
	logic signed [T_W-1:0]     ux_t [FADE_CELLS+1];
	logic signed [FW-1:0]      vy_y [FADE_CELLS+1];
	logic signed [T_W-1:0]     vy_t [FADE_CELLS+1];

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign ram_we   = in_acc && (mode == MODE_LOAD);
	assign oct_eff  = (oct_cnt_q > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : oct_cnt_q;

	assign xi = x_q[COORD_W-1:FRAC_BITS];
	assign yi = y_q[COORD_W-1:FRAC_BITS];
	assign fx = x_q[FRAC_BITS-1:0];
	assign fy = y_q[FRAC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= OCT_RESET;
			amp_cfg_q <= AMP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OCTAVES: oct_cnt_q <= cfg_data[OCT_W-1:0];
				CFG_AMP:     amp_cfg_q <= cfg_data[AMP_W-1:0];
				default:     oct_cnt_q <= oct_cnt_q;
			endcase
		end
	end

	always_comb begin
		case (step_q)
			STEP_A0: raddr = xi;
			STEP_A1: raddr = xi + 8'd1;
			STEP_A2: raddr = px0_q + yi;
			STEP_A3: raddr = px0_q + yi + 8'd1;
			STEP_A4: raddr = px1_q + yi;
			STEP_A5: raddr = px1_q + yi + 8'd1;
			default: raddr = xi;
		endcase
	end

	pnf_perm_ram u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (perm_index),
		.wdata  (perm_value),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	// fade rows: inputs held for the whole octave, output registered in the last cell
	assign ux_t[0] = T_W'({2'b00, fx});
	assign vy_t[0] = T_W'({2'b00, fy});
	assign ux_y[0] = $signed(FW'({{(FW-FRAC_BITS){1'b0}}, fx} * FW'(6)) - FW'(15 * ONE));
	assign vy_y[0] = $signed(FW'({{(FW-FRAC_BITS){1'b0}}, fy} * FW'(6)) - FW'(15 * ONE));

	for (genvar i = 0; i < FADE_CELLS; i++) begin : g_fade
		pnf_fade_cell u_cell_u (
			.clk   (clk),
			.y_in  (ux_y[i]),
			.t_in  (ux_t[i]),
			.k_in  (fade_k(i)),
			.y_out (ux_y[i+1]),
			.t_out (ux_t[i+1])
		);
		pnf_fade_cell u_cell_v (
			.clk   (clk),
			.y_in  (vy_y[i]),
			.t_in  (vy_t[i]),
			.k_in  (fade_k(i)),
			.y_out (vy_y[i+1]),
			.t_out (vy_t[i+1])
		);
	end

	assign u = ux_y[FADE_CELLS][T_W-1:0];
	assign v = vy_y[FADE_CELLS][T_W-1:0];

	assign dx0 = $signed({{(DW-FRAC_BITS){1'b0}}, fx});
	assign dy0 = $signed({{(DW-FRAC_BITS){1'b0}}, fy});
	assign dx1 = dx0 - DW'(ONE);
	assign dy1 = dy0 - DW'(ONE);

	assign amp_prod = $signed({1'b0, amp_q}) * nz_q;

	always_comb begin
		acc_sat = acc_q;
		if (acc_q > SAT_MAX) begin
			acc_sat = SAT_MAX;
		end else if (acc_q < SAT_MIN) begin
			acc_sat = SAT_MIN;
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			STEP_A1: px0_q <= rdata;
			STEP_A2: px1_q <= rdata;
			STEP_A3: h00_q <= rdata[1:0];
			STEP_A4: h01_q <= rdata[1:0];
			STEP_A5: h10_q <= rdata[1:0];
			STEP_H11: h11_q <= rdata[1:0];
			STEP_LY: begin
				ly0_q <= lerp_q(v, LW'(grad_dot(h00_q, dx0, dy0)),
					LW'(grad_dot(h01_q, dx0, dy1)));
				ly1_q <= lerp_q(v, LW'(grad_dot(h10_q, dx1, dy0)),
					LW'(grad_dot(h11_q, dx1, dy1)));
			end
			STEP_LX:  nz_q <= lerp_q(u, ly0_q, ly1_q);
			STEP_AMP: term_q <= ACC_W'($signed(amp_prod[AMP_W+LW:FRAC_BITS]));
			default: ;
		endcase
		if (in_acc) begin
			x_q   <= x_coord;
			y_q   <= y_coord;
			amp_q <= amp_cfg_q;
			acc_q <= '0;
		end else if (state_q == ST_OCT && step_q == STEP_ACC) begin
			x_q   <= {x_q[COORD_W-2:0], 1'b0};
			y_q   <= {y_q[COORD_W-2:0], 1'b0};
			amp_q <= amp_q >> 1;
			acc_q <= acc_q + term_q;
		end
		if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
			out_q <= acc_sat[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_A0;
			oct_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && mode == MODE_SAMPLE) begin
						step_q     <= STEP_A0;
						oct_left_q <= oct_eff;
						state_q    <= (oct_eff == '0) ? ST_FIN : ST_OCT;
					end
				end
				ST_OCT: begin
					if (step_q == STEP_ACC) begin
						step_q     <= STEP_A0;
						oct_left_q <= oct_left_q - OCT_W'(1);
						if (oct_left_q == OCT_W'(1)) begin
							state_q <= ST_FIN;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign noise_height = out_q;

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode == MODE_SAMPLE |=> in_stall)
		else $error("sample accepted but block not busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OCT |-> step_q <= STEP_ACC)
		else $error("octave step out of range");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish");

	a_oct_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OCT |-> oct_left_q != '0 && oct_left_q <= OCT_W'(MAX_OCTAVES))
		else $error("octave count out of range");
endmodule

[dv/tb_perlin_noise_fbm_2d.sv]
// Testbench for perlin_noise_fbm_2d: directed table then random loads and samples,
// checked against an in-bench fixed-point fBm predictor. Depends on pnf_pkg and the RTL.
module tb_perlin_noise_fbm_2d;
	timeunit 1ns;
	timeprecision 1ps;
	import pnf_pkg::*;

	typedef struct {
		logic        mode;
		logic [7:0]  pidx;
		logic [7:0]  pval;
		logic [23:0] x;
		logic [23:0] y;
		logic        has_exp;
		logic [18:0] exp_h;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [7:0] perm_index = '0;
	logic [7:0] perm_value = '0;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] noise_height;

	always #6 clk = ~clk;

	perlin_noise_fbm_2d u_top (.*);

	logic [7:0] perm_copy [256];
	logic [3:0] oct_cfg;
	logic [15:0] amp_cfg;
	logic [18:0] height_q[$];
	int errors = 0;
	int idle_tx = 0;
	int idle_rx = 0;
	int stale = 0;
	int n_out = 0;

	function automatic longint fl_mul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> 16;
	endfunction

	function automatic longint fade_of(longint t);
		longint c;
		c = fl_mul(6 * t - 15 * 65536, t) + 10 * 65536;
		return fl_mul(fl_mul(fl_mul(c, t), t), t);
	endfunction

	function automatic longint corner(logic [7:0] h, longint dx, longint dy);
		case (h[1:0])
			GRAD_PP: return dx + dy;
			GRAD_NP: return dy - dx;
			GRAD_NN: return -dx - dy;
			default: return dx - dy;
		endcase
	endfunction

	function automatic longint octave_noise(logic [23:0] x, logic [23:0] y);
		logic [7:0] xi, yi, px0, px1;
		longint fx, fy, d00, d01, d10, d11, u, v, a, b;
		xi = x[23:16];
		yi = y[23:16];
		fx = x[15:0];
		fy = y[15:0];
		px0 = perm_copy[xi];
		px1 = perm_copy[8'(xi + 8'd1)];
		d00 = corner(perm_copy[8'(px0 + yi)], fx, fy);
		d01 = corner(perm_copy[8'(px0 + yi + 8'd1)], fx, fy - 65536);
		d10 = corner(perm_copy[8'(px1 + yi)], fx - 65536, fy);
		d11 = corner(perm_copy[8'(px1 + yi + 8'd1)], fx - 65536, fy - 65536);
		u = fade_of(fx);
		v = fade_of(fy);
		a = d00 + fl_mul(v, d01 - d00);
		b = d10 + fl_mul(v, d11 - d10);
		return a + fl_mul(u, b - a);
	endfunction

	function automatic logic [18:0] fbm_height(logic [23:0] x, logic [23:0] y);
		longint acc, amp;
		int n;
		acc = 0;
		amp = amp_cfg;
		n = (oct_cfg > MAX_OCTAVES) ? MAX_OCTAVES : oct_cfg;
		for (int i = 0; i < n; i++) begin
			acc += fl_mul(amp, octave_noise(24'(x << i), 24'(y << i)));
			amp = amp >>> 1;
		end
		if (acc > 262143) acc = 262143;
		if (acc < -262144) acc = -262144;
		return 19'(acc);
	endfunction

	task automatic send(row_t r);
		logic [18:0] h;
		while ($urandom_range(99) < idle_tx) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		perm_index <= r.pidx;
		perm_value <= r.pval;
		x_coord <= r.x;
		y_coord <= r.y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (r.mode == MODE_LOAD) begin
			perm_copy[r.pidx] = r.pval;
		end else begin
			h = fbm_height(r.x, r.y);
			if (r.has_exp && h != r.exp_h) begin
				errors++;
				if (errors <= 10)
					$display("table expectation %h differs from predictor %h", r.exp_h, h);
			end
			height_q.push_back(h);
		end
	endtask

	task automatic set_reg(logic idx, logic [15:0] val);
		in_valid <= 1'b0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OCTAVES) oct_cfg = val[3:0];
		else amp_cfg = val;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_rx);
		if (out_valid && !out_stall) begin
			n_out++;
			if (height_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected height beat %h", noise_height);
			end else begin
				if (height_q[0] !== noise_height) begin
					errors++;
					if (errors <= 10)
						$display("height mismatch: exp %h got %h", height_q[0], noise_height);
				end
				void'(height_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) stale <= 0;
		else stale <= stale + 1;
		if (stale > 20000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic row_t rnd_row(bit sample);
		row_t r;
		r.mode = sample;
		r.pidx = 8'($urandom);
		r.pval = 8'($urandom);
		r.x = ($urandom_range(9) == 0) ? {$urandom_range(1) ? 8'hff : 8'h00, 16'($urandom)}
			: 24'($urandom);
		r.y = 24'($urandom);
		r.has_exp = 0;
		r.exp_h = '0;
		return r;
	endfunction

	row_t dir_tab [$];
	int phase_tx [3] = '{37, 53, 0};
	int phase_rx [3] = '{53, 37, 0};
	logic [3:0] octs [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};
	logic [15:0] amps [6] = '{16'hffff, 16'h0000, 16'd58982, 16'hffff, 16'h8000, 16'h1234};

	initial begin
		for (int i = 0; i < 256; i++) perm_copy[i] = 8'(i);
		oct_cfg = OCT_RESET;
		amp_cfg = AMP_RESET;
		// integer lattice points expect height zero; the other rows are checked by the predictor
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'h000000, 24'h000000, 1, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'hff, 8'hff, 24'hff0000, 24'h010000, 1, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'hffffff, 24'hffffff, 0, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'h008000, 24'h008000, 0, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'h00ffff, 24'h000001, 0, 19'd0});
		dir_tab.push_back('{MODE_LOAD, 8'hff, 8'h00, 24'hffffff, 24'hffffff, 0, 19'd0});
		dir_tab.push_back('{MODE_LOAD, 8'h00, 8'hff, 24'h000000, 24'h000000, 0, 19'd0});
		dir_tab.push_back('{MODE_LOAD, 8'h55, 8'haa, 24'h123456, 24'h654321, 0, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h12, 8'h34, 24'hff8000, 24'h00c000, 0, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'h557fff, 24'haa4000, 0, 19'd0});
		dir_tab.push_back('{MODE_SAMPLE, 8'h00, 8'h00, 24'h004000, 24'hff4000, 0, 19'd0});
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) send(dir_tab[i]);
		for (int p = 0; p < 6; p++) begin
			set_reg(CFG_OCTAVES, 16'(octs[p]) | 16'h0f0);
			set_reg(CFG_AMP, amps[p]);
			idle_tx = phase_tx[p % 3];
			idle_rx = phase_rx[p % 3];
			for (int k = 0; k < 300; k++) send(rnd_row($urandom_range(99) < 65));
		end
		in_valid <= 1'b0;
		while (height_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
